// ===== hw/rtl/fpvc_pkg.sv =====
// Shared widths, constants, register codes and types for the filtered pressure valve control.
`timescale 1ns / 1ps

package fpvc_pkg;

	localparam int ADC_W     = 10;
	localparam int P_W       = 13;
	localparam int SUM_W     = 17;
	localparam int REG_W     = 12;
	localparam int CFG_IDX_W = 2;

	localparam int WINDOW_LEN_DEF = 10;

	localparam logic [ADC_W-1:0] RAW_OFFSET = 10'd102;

	// ceil(12 * 256 * 2^20 / 819): exact truncation for every 10-bit offset magnitude
	localparam int              SCALE_SHIFT   = 20;
	localparam int              SCALE_RECIP_W = 22;
	localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = 22'd3933121;

	localparam logic [CFG_IDX_W-1:0] REG_LOW_THR    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPREAD = 2'd2;

	localparam logic [REG_W-1:0] LOW_THR_RST    = 12'd384;
	localparam logic [REG_W-1:0] HIGH_THR_RST   = 12'd512;
	localparam logic [REG_W-1:0] MAX_SPREAD_RST = 12'd256;

	typedef struct packed {
		logic [REG_W-1:0] low_thr;
		logic [REG_W-1:0] high_thr;
		logic [REG_W-1:0] max_spread;
	} cfg_t;

	typedef struct packed {
		logic signed [P_W-1:0]   wmin;
		logic signed [P_W-1:0]   wmax;
		logic signed [SUM_W-1:0] wsum;
	} window_t;

endpackage

// ===== hw/rtl/fpvc_if.sv =====
// Sample and result channel interfaces.
`timescale 1ns / 1ps

interface fpvc_sample_if;
	import fpvc_pkg::*;
	logic             valid;
	logic             ready;
	logic [ADC_W-1:0] adc_sample;
	modport source(output valid, output adc_sample, input ready);
	modport sink(input valid, input adc_sample, output ready);
endinterface

interface fpvc_result_if;
	import fpvc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic signed [P_W-1:0] filtered_pressure;
	logic                  pressure_error;
	logic                  valve_open;
	modport source(output valid, output filtered_pressure, output pressure_error,
		output valve_open, input ready);
	modport sink(input valid, input filtered_pressure, input pressure_error,
		input valve_open, output ready);
endinterface

// ===== hw/rtl/fpvc_scale.sv =====
// Input register and conversion of raw samples to signed Q8 bar.
`timescale 1ns / 1ps

module fpvc_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [fpvc_pkg::ADC_W-1:0]    in_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [fpvc_pkg::P_W-1:0] out_p
);
	import fpvc_pkg::*;

	localparam int PROD_W = ADC_W + SCALE_RECIP_W;

	logic                    valid_s1;
	logic                    valid_s2;
	logic [ADC_W-1:0]        raw_s1;
	logic signed [P_W-1:0]   p_s2;
	logic                    rdy_s1;
	logic                    rdy_s2;
	logic signed [ADC_W:0]   diff;
	logic                    neg;
	logic [ADC_W-1:0]        mag;
	logic [PROD_W-1:0]       prod;
	logic [P_W-1:0]          q_ext;
	logic signed [P_W-1:0]   p_c;

	assign rdy_s2   = ~valid_s2 | out_ready;
	assign rdy_s1   = ~valid_s1 | rdy_s2;
	assign in_ready = rdy_s1;

	always_comb begin
		diff  = $signed({1'b0, raw_s1}) - $signed({1'b0, RAW_OFFSET});
		neg   = diff[ADC_W];
		mag   = neg ? ADC_W'(-diff) : ADC_W'(diff);
		prod  = PROD_W'(mag) * PROD_W'(SCALE_RECIP);
		q_ext = {1'b0, prod[SCALE_SHIFT +: P_W-1]};
		p_c   = neg ? $signed(-q_ext) : $signed(q_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= in_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			raw_s1 <= in_sample;
		end
		if (rdy_s2 && valid_s1) begin
			p_s2 <= p_c;
		end
	end

	assign out_valid = valid_s2;
	assign out_p     = p_s2;

endmodule

// ===== hw/rtl/fpvc_window.sv =====
// Window accumulator: running minimum, maximum and sum, with a register for finished windows.
`timescale 1ns / 1ps

module fpvc_window #(
	parameter int WINDOW_LEN = fpvc_pkg::WINDOW_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [fpvc_pkg::P_W-1:0] in_p,
	output logic                            out_valid,
	input  logic                            out_ready,
	output fpvc_pkg::window_t               out_win
);
	import fpvc_pkg::*;

	localparam int CNT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW_LEN - 1);

	logic [CNT_W-1:0]        count_q;
	logic signed [P_W-1:0]   min_q;
	logic signed [P_W-1:0]   max_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    valid_s3;
	window_t                 win_s3;
	logic                    last;
	logic                    first;
	logic                    rdy_s3;
	logic                    take;
	logic signed [SUM_W-1:0] p_ext;
	window_t                 win_n;

	assign last     = (count_q == CNT_LAST);
	assign first    = (count_q == '0);
	assign rdy_s3   = ~valid_s3 | out_ready;
	assign in_ready = ~last | rdy_s3;
	assign take     = in_valid & in_ready;

	always_comb begin
		p_ext      = {{(SUM_W-P_W){in_p[P_W-1]}}, in_p};
		win_n.wmin = (first || (in_p < min_q)) ? in_p : min_q;
		win_n.wmax = (first || (in_p > max_q)) ? in_p : max_q;
		win_n.wsum = first ? p_ext : sum_q + p_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			min_q    <= '0;
			max_q    <= '0;
			sum_q    <= '0;
			valid_s3 <= 1'b0;
		end else begin
			if (take) begin
				count_q <= last ? '0 : count_q + 1'b1;
				min_q   <= win_n.wmin;
				max_q   <= win_n.wmax;
				sum_q   <= win_n.wsum;
			end
			if (rdy_s3) begin
				valid_s3 <= take & last;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && last) begin
			win_s3 <= win_n;
		end
	end

	assign out_valid = valid_s3;
	assign out_win   = win_s3;

endmodule

// ===== hw/rtl/fpvc_valve.sv =====
// Window average and spread check, hysteresis valve state and result register.
`timescale 1ns / 1ps

module fpvc_valve #(
	parameter int WINDOW_LEN = fpvc_pkg::WINDOW_LEN_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fpvc_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  fpvc_pkg::window_t               in_win,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [fpvc_pkg::P_W-1:0] out_pressure,
	output logic                            out_error,
	output logic                            out_valve
);
	import fpvc_pkg::*;

	localparam int AVG_SHIFT   = 20;
	localparam int AVG_RECIP_W = 21;
	localparam logic [AVG_RECIP_W-1:0] AVG_RECIP =
		AVG_RECIP_W'(((2 ** AVG_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN);
	localparam int PROD_W = SUM_W + AVG_RECIP_W;
	localparam int CMP_W  = P_W + 1;

	logic                    valid_s4;
	logic signed [P_W-1:0]   avg_s4;
	logic                    err_s4;
	logic                    out_valid_q;
	logic signed [P_W-1:0]   pressure_q;
	logic                    error_q;
	logic                    valve_state_q;
	logic                    ld_out;
	logic                    rdy_s4;
	logic                    neg;
	logic [SUM_W-1:0]        mag;
	logic [PROD_W-1:0]       prod;
	logic [P_W-1:0]          q_ext;
	logic signed [P_W-1:0]   avg_c;
	logic [CMP_W-1:0]        spread;
	logic                    err_c;
	logic signed [CMP_W-1:0] avg_x;
	logic signed [CMP_W-1:0] low_x;
	logic signed [CMP_W-1:0] high_x;
	logic                    valve_n;
	logic signed [P_W-1:0]   pressure_n;

	assign ld_out   = ~out_valid_q | out_ready;
	assign rdy_s4   = ~valid_s4 | ld_out;
	assign in_ready = rdy_s4;

	always_comb begin
		neg    = in_win.wsum[SUM_W-1];
		mag    = neg ? SUM_W'(-in_win.wsum) : SUM_W'(in_win.wsum);
		prod   = PROD_W'(mag) * PROD_W'(AVG_RECIP);
		q_ext  = {1'b0, prod[AVG_SHIFT +: P_W-1]};
		avg_c  = neg ? $signed(-q_ext) : $signed(q_ext);
		spread = CMP_W'({in_win.wmax[P_W-1], in_win.wmax} - {in_win.wmin[P_W-1], in_win.wmin});
		err_c  = !(spread < CMP_W'(cfg.max_spread));
	end

	always_comb begin
		avg_x      = {avg_s4[P_W-1], avg_s4};
		low_x      = $signed(CMP_W'(cfg.low_thr));
		high_x     = $signed(CMP_W'(cfg.high_thr));
		valve_n    = valve_state_q;
		pressure_n = avg_s4;
		if (err_s4) begin
			valve_n    = 1'b0;
			pressure_n = '0;
		end else if (!valve_state_q) begin
			if (avg_x < low_x) begin
				valve_n = 1'b1;
			end
		end else begin
			if (avg_x > high_x) begin
				valve_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4      <= 1'b0;
			out_valid_q   <= 1'b0;
			valve_state_q <= 1'b0;
		end else begin
			if (rdy_s4) begin
				valid_s4 <= in_valid;
			end
			if (ld_out) begin
				out_valid_q <= valid_s4;
			end
			if (ld_out && valid_s4) begin
				valve_state_q <= valve_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && in_valid) begin
			avg_s4 <= avg_c;
			err_s4 <= err_c;
		end
		if (ld_out && valid_s4) begin
			pressure_q <= pressure_n;
			error_q    <= err_s4;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_pressure = pressure_q;
	assign out_error    = error_q;
	assign out_valve    = valve_state_q;

endmodule

// ===== hw/rtl/filtered_pressure_valve_control.sv =====
// Top level of the filtered pressure valve control: registers, scaling, window and valve stages.
//
//   channel   | dir | handshake      | payload
//   sample    | in  | valid / ready  | adc_sample[9:0]
//   result    | out | valid / ready  | filtered_pressure[12:0] signed, pressure_error, valve_open
//   cfg       | in  | cfg_we only    | cfg_index[1:0], cfg_data[11:0]
//
// One sample accepted per cycle while the result channel is not held; the conversion multiplier
// output and the window accumulator are each registered.
// A result passes the input, scaled-pressure, finished-window, average and result registers.
// Reset clears the pipeline, the window count and the valve (closed) and loads
// the threshold registers with 384, 512 and 256.
// A held result first fills the average stage and the finished-window register; the
// accumulator then holds on the last sample of a window, and the input stalls once
// both conversion registers are full.
`timescale 1ns / 1ps

module filtered_pressure_valve_control #(
	parameter int WINDOW_LEN = fpvc_pkg::WINDOW_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	fpvc_sample_if.sink                       sample,
	fpvc_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [fpvc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fpvc_pkg::REG_W-1:0]        cfg_data
);
	import fpvc_pkg::*;

	cfg_t                  cfg_q;
	logic                  p_valid;
	logic                  p_ready;
	logic signed [P_W-1:0] p_val;
	logic                  win_valid;
	logic                  win_ready;
	window_t               win;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_thr    <= LOW_THR_RST;
			cfg_q.high_thr   <= HIGH_THR_RST;
			cfg_q.max_spread <= MAX_SPREAD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOW_THR:    cfg_q.low_thr    <= cfg_data;
				REG_HIGH_THR:   cfg_q.high_thr   <= cfg_data;
				REG_MAX_SPREAD: cfg_q.max_spread <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	fpvc_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.in_sample (sample.adc_sample),
		.out_valid (p_valid),
		.out_ready (p_ready),
		.out_p     (p_val)
	);

	fpvc_window #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (p_valid),
		.in_ready  (p_ready),
		.in_p      (p_val),
		.out_valid (win_valid),
		.out_ready (win_ready),
		.out_win   (win)
	);

	fpvc_valve #(
		.WINDOW_LEN(WINDOW_LEN)
	) u_valve (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (win_valid),
		.in_ready     (win_ready),
		.in_win       (win),
		.out_valid    (result.valid),
		.out_ready    (result.ready),
		.out_pressure (result.filtered_pressure),
		.out_error    (result.pressure_error),
		.out_valve    (result.valve_open)
	);

endmodule

// ===== hw/rtl/fpvc_checker.sv =====
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps

module fpvc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic signed [fpvc_pkg::P_W-1:0] res_pressure,
	input logic                            res_error,
	input logic                            res_valve
);
	import fpvc_pkg::*;

	localparam logic signed [P_W-1:0] PRESSURE_MIN = -13'sd382;
	localparam logic signed [P_W-1:0] PRESSURE_MAX = 13'sd3454;

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !res_valid)
		else $error("result valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_pressure)
			&& $stable(res_error) && $stable(res_valve))
		else $error("stalled result transaction changed");

	a_error_closes: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_error |-> !res_valve && (res_pressure == '0))
		else $error("error result with open valve or non-zero pressure");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_pressure >= PRESSURE_MIN) && (res_pressure <= PRESSURE_MAX))
		else $error("filtered pressure out of range");

endmodule

bind filtered_pressure_valve_control fpvc_checker u_fpvc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_pressure (result.filtered_pressure),
	.res_error    (result.pressure_error),
	.res_valve    (result.valve_open)
);
